>>> hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/chse_pkg.sv
// Shared types and constants of the spline evaluator.
// No dependencies.
package chse_pkg;

    localparam int DATA_W        = 32;
    localparam int CFG_W         = 5;
    localparam int SLOT_W        = 4;
    localparam int POS_W         = 2;
    localparam int FRAC_BITS     = 16;
    localparam int KBITS         = 30;
    localparam int DIV_STEPS     = KBITS + 1;
    localparam int MAX_KNOTS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int KNOT_CNT_RST  = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [POS_W-1:0] POS_INSIDE = 2'd0;
    localparam logic [POS_W-1:0] POS_BELOW  = 2'd1;
    localparam logic [POS_W-1:0] POS_BEYOND = 2'd2;

    // Classified work item; coord is the knot location for a load, x for an evaluate.
    typedef struct packed {
        logic                     is_eval;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] coord;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] slope;
    } t_entry;

endpackage

>>> hdl/chse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module chse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/chse_front.sv
// Front end: accepts input beats, drops loads to slots beyond the table,
// and packs the rest into queue entries. Depends on chse_pkg.
module chse_front #(
    parameter int MAX_KNOTS = chse_pkg::MAX_KNOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_operation,
    input  logic [chse_pkg::SLOT_W-1:0]       i_knot_index,
    input  logic signed [chse_pkg::DATA_W-1:0] i_knot_location,
    input  logic signed [chse_pkg::DATA_W-1:0] i_knot_value,
    input  logic signed [chse_pkg::DATA_W-1:0] i_knot_slope,
    input  logic signed [chse_pkg::DATA_W-1:0] i_sample_x,
    output logic                              o_q_push,
    output chse_pkg::t_entry                  o_q_data,
    input  logic                              i_q_full
);
    import chse_pkg::*;

    logic   r_vld;
    t_entry r_entry;
    logic   accept;
    logic   drop;
    logic   is_eval;

    assign is_eval  = (i_operation == OP_EVAL);
    assign drop     = !is_eval && (32'(i_knot_index) >= 32'(MAX_KNOTS));
    assign o_full   = r_vld && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_vld && !i_q_full;
    assign o_q_data = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= !drop;
        end else if (o_q_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry.is_eval <= is_eval;
            r_entry.slot    <= i_knot_index;
            r_entry.coord   <= is_eval ? i_sample_x : i_knot_location;
            r_entry.value   <= i_knot_value;
            r_entry.slope   <= i_knot_slope;
        end
    end

endmodule

>>> hdl/chse_queue.sv
// Short queue of classified entries between front and back end.
// Depends on chse_pkg.
module chse_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  chse_pkg::t_entry i_data,
    output logic             o_full,
    input  logic             i_pop,
    output chse_pkg::t_entry o_data,
    output logic             o_empty
);
    import chse_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_entry            r_slot [QUEUE_DEPTH];
    logic [PW-1:0]     r_wptr;
    logic [PW-1:0]     r_rptr;
    logic [PW:0]       r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

>>> hdl/chse_back.sv
// Back end: knot tables, binary search, min/max sweep, serial divider and
// shared multiplier sequence, result register. Depends on chse_pkg, chse_ram.
module chse_back #(
    parameter int MAX_KNOTS = chse_pkg::MAX_KNOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [chse_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                               i_q_empty,
    output logic                               o_q_pop,
    input  chse_pkg::t_entry                   i_q_data,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic signed [chse_pkg::DATA_W-1:0] o_result_y,
    output logic [chse_pkg::POS_W-1:0]         o_position,
    output logic signed [chse_pkg::DATA_W-1:0] o_min_value,
    output logic signed [chse_pkg::DATA_W-1:0] o_max_value
);
    import chse_pkg::*;

    localparam int AW = $clog2(MAX_KNOTS);
    localparam int NW = $clog2(MAX_KNOTS + 1);
    localparam int DW = DATA_W + 2;
    localparam int MW = 34;
    localparam int PRW = 2 * MW;
    localparam int AccW = 64;
    localparam int KW = KBITS + 1;
    localparam int DCW = $clog2(DIV_STEPS);
    localparam int MUL_LAST = 10;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SADDR = 4'd1;
    localparam logic [3:0] ST_SCMP  = 4'd2;
    localparam logic [3:0] ST_MM    = 4'd3;
    localparam logic [3:0] ST_F0    = 4'd4;
    localparam logic [3:0] ST_F1    = 4'd5;
    localparam logic [3:0] ST_F2    = 4'd6;
    localparam logic [3:0] ST_PREP  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_MUL   = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    localparam logic signed [AccW-1:0] Y_MAX = (AccW'(1) <<< (DATA_W-1)) - AccW'(1);
    localparam logic signed [AccW-1:0] Y_MIN = -Y_MAX - AccW'(1);
    localparam logic [MW-1:0] KONE_M = MW'(1) << KBITS;

    logic [3:0]                r_state;
    logic [CFG_W-1:0]          r_knot_count;
    logic [NW-1:0]             r_n;
    logic signed [DATA_W-1:0]  r_x;
    logic [NW-1:0]             r_lo;
    logic [NW-1:0]             r_len;
    logic [NW-1:0]             r_mid;
    logic [AW-1:0]             r_a0;
    logic [POS_W-1:0]          r_pos;
    logic [NW-1:0]             r_cnt;
    logic                      r_cap;
    logic                      r_first;
    logic signed [DATA_W-1:0]  r_min;
    logic signed [DATA_W-1:0]  r_max;
    logic signed [DATA_W-1:0]  r_loc0, r_val0, r_slp0;
    logic signed [DATA_W-1:0]  r_loc1, r_val1, r_slp1;
    logic signed [DW-1:0]      r_dx;
    logic signed [DW-1:0]      r_dy;
    logic [DW:0]               r_rem;
    logic [KW-1:0]             r_k;
    logic [DCW-1:0]            r_dcnt;
    logic [3:0]                r_step;
    logic                      r_phase;
    logic signed [PRW-1:0]     r_prod;
    logic signed [AccW-1:0]    r_s, r_p, r_a, r_inner, r_acc, r_y;
    logic [KW-1:0]             r_w;
    logic                      r_ov;
    logic signed [DATA_W-1:0]  r_oy;
    logic [POS_W-1:0]          r_opos;
    logic signed [DATA_W-1:0]  r_omin;
    logic signed [DATA_W-1:0]  r_omax;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [AW-1:0]             loc_ra, val_ra, slp_ra;
    logic signed [DATA_W-1:0]  loc_rd, val_rd, slp_rd;
    logic [NW-1:0]             half;
    logic [NW-1:0]             mid_c;
    logic [NW-1:0]             n_clamp;
    logic signed [DW-1:0]      dx_c, tt_c, t_c;
    logic                      div_ge;
    logic [DW:0]               rem_nx;
    logic signed [MW-1:0]      op_a, op_b;
    logic signed [AccW-1:0]    p64, sh_f, sh_k, dy64;
    logic signed [AccW-1:0]    y_sat;
    logic                      out_load;
    int                        kc_i;

    // Tables
    assign o_q_pop   = (r_state == ST_IDLE) && !i_q_empty;
    assign ram_we    = o_q_pop && !i_q_data.is_eval;
    assign ram_waddr = AW'(i_q_data.slot);

    chse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS)) u_loc_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(i_q_data.coord),
        .i_raddr(loc_ra), .o_rdata(loc_rd)
    );
    chse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS)) u_val_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(i_q_data.value),
        .i_raddr(val_ra), .o_rdata(val_rd)
    );
    chse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS)) u_slp_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(i_q_data.slope),
        .i_raddr(slp_ra), .o_rdata(slp_rd)
    );

    assign half  = r_len >> 1;
    assign mid_c = r_lo + half;

    always_comb begin
        kc_i = int'(r_knot_count);
        if (kc_i < 2) begin
            n_clamp = NW'(2);
        end else if (kc_i > MAX_KNOTS) begin
            n_clamp = NW'(MAX_KNOTS);
        end else begin
            n_clamp = NW'(kc_i);
        end
    end

    always_comb begin
        loc_ra = AW'(mid_c);
        val_ra = AW'(r_cnt);
        slp_ra = r_a0;
        if (r_state == ST_F0) begin
            loc_ra = r_a0;
            val_ra = r_a0;
        end else if (r_state == ST_F1) begin
            loc_ra = r_a0 + 1'b1;
            val_ra = r_a0 + 1'b1;
            slp_ra = r_a0 + 1'b1;
        end
    end

    // Interval set-up
    assign dx_c = DW'(r_loc1) - DW'(r_loc0);
    assign tt_c = DW'(r_x) - DW'(r_loc0);
    assign t_c  = (tt_c < 0) ? '0 : ((tt_c > dx_c) ? dx_c : tt_c);

    // Restoring divide, one quotient bit per cycle
    assign div_ge = r_rem >= (DW+1)'(r_dx);
    assign rem_nx = div_ge ? r_rem - (DW+1)'(r_dx) : r_rem;

    // Operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_step)
            4'd0: begin
                op_a = MW'(r_slp0);
                op_b = MW'(r_dx >>> FRAC_BITS);
            end
            4'd1: begin
                op_a = MW'(r_slp0);
                op_b = MW'(r_dx[FRAC_BITS-1:0]);
            end
            4'd2: begin
                op_a = MW'(r_slp1);
                op_b = MW'(r_dx >>> FRAC_BITS);
            end
            4'd3: begin
                op_a = MW'(r_slp1);
                op_b = MW'(r_dx[FRAC_BITS-1:0]);
            end
            4'd4: begin
                op_a = MW'(r_a >>> KBITS);
                op_b = MW'(r_k);
            end
            4'd5: begin
                op_a = MW'(r_a[KBITS-1:0]);
                op_b = MW'(r_k);
            end
            4'd6: begin
                op_a = MW'(r_k);
                op_b = KONE_M - MW'(r_k);
            end
            4'd7: begin
                op_a = MW'(r_dy >>> KBITS);
                op_b = MW'(r_k);
            end
            4'd8: begin
                op_a = MW'(r_dy[KBITS-1:0]);
                op_b = MW'(r_k);
            end
            4'd9: begin
                op_a = MW'(r_inner >>> KBITS);
                op_b = MW'(r_w);
            end
            4'd10: begin
                op_a = MW'(r_inner[KBITS-1:0]);
                op_b = MW'(r_w);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign p64  = AccW'(r_prod);
    assign sh_f = AccW'(r_prod >>> FRAC_BITS);
    assign sh_k = AccW'(r_prod >>> KBITS);
    assign dy64 = AccW'(r_dy);

    assign y_sat    = (r_y > Y_MAX) ? Y_MAX : ((r_y < Y_MIN) ? Y_MIN : r_y);
    assign out_load = (r_state == ST_DONE) && (!r_ov || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= CFG_W'(KNOT_CNT_RST);
        end else if (i_cfg_we) begin
            r_knot_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_q_pop && i_q_data.is_eval) begin
                        r_state <= ST_SADDR;
                    end
                end
                ST_SADDR: begin
                    if (r_len == '0) begin
                        r_state <= ST_MM;
                    end else begin
                        r_state <= ST_SCMP;
                    end
                end
                ST_SCMP: r_state <= ST_SADDR;
                ST_MM: begin
                    if (r_cnt == r_n && !r_cap) begin
                        r_state <= ST_F0;
                    end
                end
                ST_F0:   r_state <= ST_F1;
                ST_F1:   r_state <= ST_F2;
                ST_F2:   r_state <= ST_PREP;
                ST_PREP: begin
                    if (r_pos != POS_INSIDE || dx_c <= 0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_dcnt == DCW'(DIV_STEPS-1)) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_phase && r_step == 4'(MUL_LAST)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x   <= i_q_data.coord;
                r_n   <= n_clamp;
                r_lo  <= '0;
                r_len <= n_clamp;
            end
            ST_SADDR: begin
                r_mid   <= mid_c;
                r_cnt   <= '0;
                r_cap   <= 1'b0;
                r_first <= 1'b1;
                if (r_lo == '0) begin
                    r_pos <= POS_BELOW;
                    r_a0  <= '0;
                end else if (r_lo == r_n) begin
                    r_pos <= POS_BEYOND;
                    r_a0  <= AW'(r_lo - 1'b1);
                end else begin
                    r_pos <= POS_INSIDE;
                    r_a0  <= AW'(r_lo - 1'b1);
                end
            end
            ST_SCMP: begin
                if (r_x < loc_rd) begin
                    r_len <= half;
                end else begin
                    r_lo  <= r_mid + 1'b1;
                    r_len <= r_len - half - 1'b1;
                end
            end
            ST_MM: begin
                // issue one read per cycle, fold in the registered read data on the next cycle
                if (r_cnt < r_n) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_cap <= 1'b1;
                end else begin
                    r_cap <= 1'b0;
                end
                if (r_cap) begin
                    r_first <= 1'b0;
                    if (r_first || val_rd < r_min) begin
                        r_min <= val_rd;
                    end
                    if (r_first || val_rd > r_max) begin
                        r_max <= val_rd;
                    end
                end
            end
            ST_F1: begin
                r_loc0 <= loc_rd;
                r_val0 <= val_rd;
                r_slp0 <= slp_rd;
            end
            ST_F2: begin
                r_loc1 <= loc_rd;
                r_val1 <= val_rd;
                r_slp1 <= slp_rd;
            end
            ST_PREP: begin
                r_dx    <= dx_c;
                r_dy    <= DW'(r_val1) - DW'(r_val0);
                r_rem   <= (DW+1)'(t_c);
                r_k     <= '0;
                r_dcnt  <= '0;
                r_step  <= '0;
                r_phase <= 1'b0;
                r_y     <= AccW'(r_val0);
            end
            ST_DIV: begin
                r_rem  <= rem_nx << 1;
                r_k    <= {r_k[KW-2:0], div_ge};
                r_dcnt <= r_dcnt + 1'b1;
            end
            ST_MUL: begin
                if (!r_phase) begin
                    r_prod  <= op_a * op_b;
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    r_step  <= r_step + 1'b1;
                    case (r_step)
                        4'd0:    r_s     <= p64;
                        4'd1:    r_p     <= r_s + sh_f - dy64;
                        4'd2:    r_s     <= p64;
                        4'd3:    r_a     <= (dy64 - r_p) - (r_s + sh_f);
                        4'd4:    r_s     <= p64;
                        4'd5:    r_inner <= r_p + r_s + sh_k;
                        4'd6:    r_w     <= KW'(r_prod >>> KBITS);
                        4'd7:    r_s     <= p64;
                        4'd8:    r_acc   <= AccW'(r_val0) + r_s + sh_k;
                        4'd9:    r_s     <= p64;
                        4'd10:   r_y     <= r_acc + r_s + sh_k;
                        default: r_s     <= r_s;
                    endcase
                end
            end
            default: begin
                r_x <= r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oy   <= DATA_W'(y_sat);
            r_opos <= r_pos;
            r_omin <= r_min;
            r_omax <= r_max;
        end
    end

    assign o_empty     = !r_ov;
    assign o_result_y  = r_oy;
    assign o_position  = r_opos;
    assign o_min_value = r_omin;
    assign o_max_value = r_omax;

endmodule

>>> hdl/cubic_hermite_spline_eval_top.sv
// Top level of the cubic Hermite spline evaluator.
// Depends on chse_pkg, chse_front, chse_queue, chse_back.
//
// Input side is a queue: drive an item with push while full is low. A load
// item (operation 0) writes one knot slot; an evaluate item (operation 1)
// interpolates at sample_x. Result side is a queue too: while empty is low the
// result of the oldest evaluate is on the output ports; pop takes it. Loads
// give no result. knot_count is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while the block is idle, the block itself does not enforce this.
// The front register and a two-entry queue take items while the back end is
// busy. The back end runs one item at a time: a load just writes the tables;
// an evaluate runs a binary search, a min/max sweep over the value table,
// fetch and set-up, the serial divider and the shared multiplier sequence.
// Points outside the knots, and intervals of zero or negative width, skip
// the divide and multiply. Items pass through the front register and the
// queue before they reach the back end.
// Reset empties both queues and sets knot_count to 2; knot tables are left
// unwritten. A stalled result holds the back end and, once the queue fills,
// raises full.
module cubic_hermite_spline_eval_top #(
    parameter int MAX_KNOTS = chse_pkg::MAX_KNOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_operation,
    input  logic [chse_pkg::SLOT_W-1:0]        i_knot_index,
    input  logic signed [chse_pkg::DATA_W-1:0] i_knot_location,
    input  logic signed [chse_pkg::DATA_W-1:0] i_knot_value,
    input  logic signed [chse_pkg::DATA_W-1:0] i_knot_slope,
    input  logic signed [chse_pkg::DATA_W-1:0] i_sample_x,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [chse_pkg::DATA_W-1:0] o_result_y,
    output logic [chse_pkg::POS_W-1:0]         o_position,
    output logic signed [chse_pkg::DATA_W-1:0] o_min_value,
    output logic signed [chse_pkg::DATA_W-1:0] o_max_value,
    input  logic                               i_cfg_we,
    input  logic [chse_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import chse_pkg::*;

    logic   q_push, q_full, q_pop, q_empty;
    t_entry q_in, q_out;

    chse_front #(.MAX_KNOTS(MAX_KNOTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .o_full(full),
        .i_operation(i_operation), .i_knot_index(i_knot_index),
        .i_knot_location(i_knot_location), .i_knot_value(i_knot_value),
        .i_knot_slope(i_knot_slope), .i_sample_x(i_sample_x),
        .o_q_push(q_push), .o_q_data(q_in), .i_q_full(q_full)
    );

    chse_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_data(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_data(q_out), .o_empty(q_empty)
    );

    chse_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_q_empty(q_empty), .o_q_pop(q_pop), .i_q_data(q_out),
        .o_empty(empty), .i_pop(pop),
        .o_result_y(o_result_y), .o_position(o_position),
        .o_min_value(o_min_value), .o_max_value(o_max_value)
    );

endmodule

>>> hdl/chse_checker.sv
// Port-level checks of the spline evaluator, bound to the top level.
// Depends on chse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module chse_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               empty,
    input logic                               pop,
    input logic signed [chse_pkg::DATA_W-1:0] o_result_y,
    input logic [chse_pkg::POS_W-1:0]         o_position,
    input logic signed [chse_pkg::DATA_W-1:0] o_min_value,
    input logic signed [chse_pkg::DATA_W-1:0] o_max_value
);
    import chse_pkg::*;

    `ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, empty)

    `ASSERT_NEXT(a_stall_hold, i_clk, !i_rst_n, !empty && !pop, !empty && $stable(o_result_y))

    `ASSERT_IMPLY(a_min_le_max, i_clk, !i_rst_n, !empty, o_min_value <= o_max_value)

    // outside the knots the result is an end knot value, so it lies within the extremes
    `ASSERT_IMPLY(a_outside_in_range, i_clk, !i_rst_n, !empty && o_position != POS_INSIDE, o_result_y >= o_min_value && o_result_y <= o_max_value)

endmodule

bind cubic_hermite_spline_eval_top chse_checker u_chse_checker (.*);
